FILE: sv/ccr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg: shared types and constants for the circle canvas rasterizer
// Item codes, status codes, controller states, field widths and the
// packing of the stream payloads.
// ----------------------------------------------------------------------------
package ccr_pkg;

  // default geometry and fixed point format
  localparam int MAX_SIDE_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  // field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 20;
  localparam int CHAR_W   = 8;
  localparam int PIX_W    = 8;
  localparam int SIDE_W   = 9;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // input tdata layout, lowest bit first
  localparam int IN_FILLED_LSB = 0;
  localparam int IN_CX_LSB     = IN_FILLED_LSB + 1;
  localparam int IN_CY_LSB     = IN_CX_LSB + COORD_W;
  localparam int IN_R_LSB      = IN_CY_LSB + COORD_W;
  localparam int IN_CHAR_LSB   = IN_R_LSB + COORD_W;
  localparam int IN_COL_LSB    = IN_CHAR_LSB + CHAR_W;
  localparam int IN_ROW_LSB    = IN_COL_LSB + PIX_W;
  localparam int IN_USED_W     = IN_ROW_LSB + PIX_W;
  localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  // configuration reset values
  localparam logic [SIDE_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [SIDE_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [CHAR_W-1:0] BG_RST     = 8'd32;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } ccr_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_BAD_RADIUS = 2'd1,
    ST_OUTSIDE    = 2'd2
  } ccr_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } ccr_state_t;

endpackage

FILE: sv/circle_canvas_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_canvas_rasterizer: character canvas with circle drawing
// Keeps a canvas of characters in one on-chip memory; clears it, paints
// filled or outlined circles into it and reads single pixels back.
// ----------------------------------------------------------------------------
// A clear item, or a draw item with a positive radius, sweeps the canvas
// in use, one pixel per cycle. A draw goes through setup first; both end
// with the pipeline drain and the result hand-off. The sweep rate is set
// by the single write port of the canvas memory. A read item does one
// registered memory read, then gives the result. One item is worked on at
// a time; the next item is taken once the result of the current one sits
// in the output register. Every item gives exactly one result: status in
// out_tuser and, for a read inside the canvas, the read character in
// out_tdata (zero otherwise). Pixels never written since reset read back
// as arbitrary values.
module circle_canvas_rasterizer
  import ccr_pkg::*;
#(
  parameter int MAX_SIDE  = MAX_SIDE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // bits low to high: filled, center_x, center_y, circle_radius,
  // fill_char, pixel_col, pixel_row, zero pad
  input  logic [IN_DATA_W-1:0] in_tdata,
  // bits: operation
  input  logic [OP_W-1:0]      in_tuser,
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // bits: pixel_char
  output logic [PIX_W-1:0]     out_tdata,
  // bits: status
  output logic [STATUS_W-1:0]  out_tuser,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIDE_W-1:0]    cfg_data
);

  localparam int XW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int RW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = ((XW + FRAC_BITS > COORD_W) ? XW + FRAC_BITS : COORD_W) + 2;
  localparam int SQW   = 2 * DW + 1;
  localparam int RSQW  = 2 * (COORD_W - 1);
  localparam int AXW   = RW + PIX_W;
  localparam int CMPW  = SW + PIX_W;

  // configuration registers
  logic [SIDE_W-1:0] cfg_width_r, cfg_height_r;
  logic [CHAR_W-1:0] cfg_bg_r;

  // controller
  ccr_state_t state_r, state_nxt;
  logic       accept, load_out, sweep_en;

  // latched item
  logic                      disc_r, clr_mode_r, rd_op_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, rad_r;
  logic [CHAR_W-1:0]         wr_char_r;
  ccr_status_t               status_r;
  logic [SW-1:0]             w_r, h_r;
  logic [RSQW-1:0]           outer_r, inner_r;
  logic                      rin_ge0_r;

  // sweep counters
  logic [XW-1:0] x_r, y_r;
  logic [RW-1:0] addr_r, row_base_r;
  logic          x_last, y_last;

  // pixel pipeline
  logic                 v1_r, v2_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic [RW-1:0]        a1_r, a2_r;
  logic [2*DW-1:0]      dx2_r, dy2_r;

  // output register
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_char_r;
  ccr_status_t       out_status_r;

  // canvas memory
  logic [CHAR_W-1:0] canvas_mem [DEPTH];
  logic [CHAR_W-1:0] rd_q_r;

  // input field views
  ccr_op_t                   in_op;
  logic                      in_filled;
  logic signed [COORD_W-1:0] in_cx, in_cy, in_rad;
  logic [CHAR_W-1:0]         in_char;
  logic [PIX_W-1:0]          in_col, in_row;

  assign in_op     = ccr_op_t'(in_tuser);
  assign in_filled = in_tdata[IN_FILLED_LSB];
  assign in_cx     = in_tdata[IN_CX_LSB +: COORD_W];
  assign in_cy     = in_tdata[IN_CY_LSB +: COORD_W];
  assign in_rad    = in_tdata[IN_R_LSB +: COORD_W];
  assign in_char   = in_tdata[IN_CHAR_LSB +: CHAR_W];
  assign in_col    = in_tdata[IN_COL_LSB +: PIX_W];
  assign in_row    = in_tdata[IN_ROW_LSB +: PIX_W];

  assign accept = in_tvalid && in_tready;

  // configuration writes, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RST;
      cfg_height_r <= HEIGHT_RST;
      cfg_bg_r     <= BG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  cfg_width_r  <= cfg_data;
        REG_HEIGHT: cfg_height_r <= cfg_data;
        REG_BG:     cfg_bg_r     <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // sides in use, clamped to one..MAX_SIDE
  logic [SW-1:0] w_use, h_use;

  always_comb begin
    if (cfg_width_r == '0)
      w_use = SW'(1);
    else if (32'(cfg_width_r) > MAX_SIDE)
      w_use = SW'(MAX_SIDE);
    else
      w_use = SW'(cfg_width_r);
    if (cfg_height_r == '0)
      h_use = SW'(1);
    else if (32'(cfg_height_r) > MAX_SIDE)
      h_use = SW'(MAX_SIDE);
    else
      h_use = SW'(cfg_height_r);
  end

  // read item decode
  logic          rd_inside;
  logic [RW-1:0] rd_addr;

  assign rd_inside = (CMPW'(in_col) < CMPW'(w_use)) && (CMPW'(in_row) < CMPW'(h_use));
  assign rd_addr   = RW'(AXW'(in_row) * AXW'(MAX_SIDE) + AXW'(in_col));

  logic rad_pos;
  assign rad_pos = !in_rad[COORD_W-1] && (in_rad != '0);

  // sweep end detection
  assign x_last = ((SW + 1)'(x_r) + (SW + 1)'(1)) == (SW + 1)'(w_r);
  assign y_last = ((SW + 1)'(y_r) + (SW + 1)'(1)) == (SW + 1)'(h_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: state_nxt = S_SWEEP;
            OP_DRAW:  state_nxt = rad_pos ? S_SETUP : S_DONE;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_SETUP: state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (x_last && y_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_tready = 1'b0;
    sweep_en  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_SWEEP: sweep_en = 1'b1;
      S_DONE:  load_out = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // item latch on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      disc_r     <= in_filled;
      cx_r       <= in_cx;
      cy_r       <= in_cy;
      rad_r      <= in_rad;
      w_r        <= w_use;
      h_r        <= h_use;
      clr_mode_r <= (in_op == OP_CLEAR);
      rd_op_r    <= (in_op == OP_READ);
      wr_char_r  <= (in_op == OP_CLEAR) ? cfg_bg_r : in_char;
      case (in_op)
        OP_DRAW: status_r <= rad_pos ? ST_OK : ST_BAD_RADIUS;
        OP_READ: status_r <= rd_inside ? ST_OK : ST_OUTSIDE;
        default: status_r <= ST_OK;
      endcase
    end
  end

  // squared radii for the draw compare
  logic signed [COORD_W:0] rin;
  assign rin = (COORD_W + 1)'(rad_r) - (COORD_W + 1)'(1 << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      outer_r   <= RSQW'(rad_r[COORD_W-2:0]) * RSQW'(rad_r[COORD_W-2:0]);
      inner_r   <= RSQW'(rin[COORD_W-2:0]) * RSQW'(rin[COORD_W-2:0]);
      rin_ge0_r <= !rin[COORD_W];
    end
  end

  // sweep counters, row-major over the canvas in use
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r        <= '0;
      y_r        <= '0;
      addr_r     <= '0;
      row_base_r <= '0;
    end else if (sweep_en) begin
      if (x_last) begin
        x_r        <= '0;
        y_r        <= y_r + XW'(1);
        addr_r     <= row_base_r + RW'(MAX_SIDE);
        row_base_r <= row_base_r + RW'(MAX_SIDE);
      end else begin
        x_r    <= x_r + XW'(1);
        addr_r <= addr_r + RW'(1);
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= sweep_en;
      v2_r <= v1_r;
    end
  end

  // stage 1: offsets from the centre
  logic [DW-1:0] x_fix, y_fix;
  assign x_fix = DW'(x_r) << FRAC_BITS;
  assign y_fix = DW'(y_r) << FRAC_BITS;

  always_ff @(posedge clk) begin
    dx_r <= $signed(x_fix) - DW'(cx_r);
    dy_r <= $signed(y_fix) - DW'(cy_r);
    a1_r <= addr_r;
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    dx2_r <= $unsigned((2 * DW)'(dx_r) * (2 * DW)'(dx_r));
    dy2_r <= $unsigned((2 * DW)'(dy_r) * (2 * DW)'(dy_r));
    a2_r  <= a1_r;
  end

  // stage 3: distance compare and canvas write
  logic [SQW-1:0] d2;
  logic           in_disc, wr_en;

  assign d2      = SQW'(dx2_r) + SQW'(dy2_r);
  assign in_disc = (d2 <= SQW'(outer_r))
                   && (disc_r || !rin_ge0_r || (d2 > SQW'(inner_r)));
  assign wr_en   = v2_r && (clr_mode_r || in_disc);

  always_ff @(posedge clk) begin
    if (wr_en) canvas_mem[a2_r] <= wr_char_r;
  end

  // pixel read, registered
  always_ff @(posedge clk) begin
    if (accept && (in_op == OP_READ) && rd_inside) rd_q_r <= canvas_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_char_r   <= (rd_op_r && (status_r == ST_OK)) ? rd_q_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // canvas is written only while a sweep is in flight
  a_wr_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SWEEP || state_r == S_DRAIN))
    else $error("canvas write outside a sweep");

  // a new item is taken only with the pixel pipeline empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!v1_r && !v2_r))
    else $error("item accepted with pixels in flight");

  // sweep counters stay inside the canvas in use
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_en |-> (((SW + 1)'(x_r) < (SW + 1)'(w_r)) && ((SW + 1)'(y_r) < (SW + 1)'(h_r))))
    else $error("sweep counter beyond canvas");

  // a finished item always lands in the output register
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_tvalid && state_r == S_IDLE))
    else $error("result not presented");
`endif

endmodule
